>>> design/pau_pkg.sv
// ============================================================================
// pau_pkg
// Shared widths, register map, side-band struct and arithmetic steps of the
// particle attractor update pipeline.
// ============================================================================
package pau_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = FRAC_BITS + 4;        // position / velocity fields
    localparam int AXIS_W    = FRAC_BITS + 2;        // attractor coordinates
    localparam int POS_W     = VAL_W + 1;            // position after the step
    localparam int OFF_W     = VAL_W + 2;            // signed offset to attractor
    localparam int MAG_W     = VAL_W + 1;            // offset magnitude
    localparam int SQ_W      = 2 * MAG_W;            // one squared offset
    localparam int D2_W      = 2 * MAG_W + 1;        // squared distance
    localparam int DIST_W    = (D2_W + 1) / 2;       // distance (square root)
    localparam int RAD_W     = 2 * DIST_W;           // padded radicand
    localparam int SREM_W    = DIST_W + 3;           // square root remainder

    // pull = strength * 2^(2F) / d2, quotient bits below the overflow bit
    localparam int PQ_W      = VAL_W;
    localparam int PDIV_W    = D2_W + PQ_W;
    localparam int PULL_STG  = DIST_W;               // covers PQ_W + 1 divide steps too

    // change = |pull| * |offset| / dist, clamped to 2^VQ_W
    localparam int PROD_W    = VAL_W + MAG_W;
    localparam int VQ_W      = VAL_W + 2;
    localparam int VDIV_W    = DIST_W + VQ_W;
    localparam int VEL_STG   = VQ_W + 1;
    localparam int CHG_W     = VQ_W + 1;
    localparam int NV_W      = VQ_W + 3;

    // configuration port
    localparam int DATA_W    = (VAL_W > 32) ? 64 : 32;
    localparam int ADDR_LSB  = (VAL_W > 32) ? 3 : 2;
    localparam int REG_IDX_W = 2;
    localparam int ADDR_W    = ADDR_LSB + REG_IDX_W;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ATTR_X   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ATTR_Y   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_STRENGTH = 2'd3;

    // constants
    localparam logic signed [AXIS_W-1:0] AXIS_ONE     = AXIS_W'(longint'(1) << FRAC_BITS);
    localparam logic signed [AXIS_W-1:0] AXIS_NEG_ONE = -AXIS_ONE;
    localparam logic signed [POS_W-1:0]  POS_TWO      = POS_W'(longint'(2) << FRAC_BITS);
    localparam logic signed [POS_W-1:0]  POS_NEG_TWO  = -POS_TWO;
    localparam logic signed [VAL_W-1:0]  VAL_TWO      = VAL_W'(longint'(2) << FRAC_BITS);
    localparam logic signed [VAL_W-1:0]  VAL_NEG_TWO  = -VAL_TWO;
    localparam logic [CHG_W-1:0]         CHG_LIM      = CHG_W'(1) << VQ_W;
    localparam logic signed [NV_W-1:0]   VEL_MAX      = NV_W'((longint'(1) << (VAL_W - 1)) - 1);
    localparam logic signed [NV_W-1:0]   VEL_MIN      = -NV_W'(longint'(1) << (VAL_W - 1));

    typedef struct packed {
        logic                          enable;
        logic signed [AXIS_W-1:0]      ax;
        logic signed [AXIS_W-1:0]      ay;
        logic signed [VAL_W-1:0]       strength;
    } cfg_t;

    // particle state that travels beside the arithmetic
    typedef struct packed {
        logic signed [POS_W-1:0]       px;
        logic signed [POS_W-1:0]       py;
        logic signed [VAL_W-1:0]       vx;
        logic signed [VAL_W-1:0]       vy;
        logic                          moving;
        logic                          act;     // pull applies to velocity
        logic                          stop;    // sits exactly on the attractor
        logic                          oob;     // position goes back to origin
        logic                          dxneg;
        logic                          dyneg;
        logic [MAG_W-1:0]              dxmag;
        logic [MAG_W-1:0]              dymag;
    } side_t;

    // magnitude of a signed offset
    function automatic logic [MAG_W-1:0] off_mag(input logic signed [OFF_W-1:0] v);
        logic signed [OFF_W-1:0] n;
        begin
            n = -v;
            off_mag = v[OFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
        end
    endfunction

    // velocity minus signed change, saturated to the field range
    function automatic logic signed [VAL_W-1:0] sat_vel(input logic signed [VAL_W-1:0] v,
                                                        input logic [CHG_W-1:0] m,
                                                        input logic neg);
        logic signed [NV_W-1:0] chg;
        logic signed [NV_W-1:0] nv;
        begin
            chg = neg ? -$signed(NV_W'(m)) : $signed(NV_W'(m));
            nv  = $signed({{(NV_W-VAL_W){v[VAL_W-1]}}, v}) - chg;
            if (nv > VEL_MAX)
                sat_vel = VEL_MAX[VAL_W-1:0];
            else if (nv < VEL_MIN)
                sat_vel = VEL_MIN[VAL_W-1:0];
            else
                sat_vel = nv[VAL_W-1:0];
        end
    endfunction

endpackage

>>> design/particle_attractor_update.sv
// ============================================================================
// particle_attractor_update
// One particle time step with a point attractor, fully pipelined.
// ============================================================================
// Usage:
//   Input stream s_axis_*: one particle per transaction, tdata holds pos_x,
//   pos_y, vel_x, vel_y and tuser the moving flag. Output stream m_axis_*
//   returns the next state in the same layout, one result per input, in order.
//   The APB port holds attract_enable, attract_x, attract_y and pull_strength
//   at byte addresses 0, 4, 8 and 12; write them only while no particle is
//   in flight.
//   The pipeline consists of three front stages, one square root / pull divide
//   step per stage, the pull clamp and multiply stages, one velocity divide
//   bit per stage and the output register.
//   Throughput is one particle per cycle while the output is taken.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis_tready drops; no item is lost or repeated.
//   Reset clears all valid bits and the configuration registers.
// ============================================================================
module particle_attractor_update (
    input  logic                              clk,
    input  logic                              rst_n,
    // particle in: tdata = pos_x, pos_y, vel_x, vel_y (lowest first)
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [4*pau_pkg::VAL_W-1:0]       s_axis_tdata,
    input  logic                              s_axis_tuser,   // moving
    // particle out: tdata = next_x, next_y, next_vel_x, next_vel_y (lowest first)
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [4*pau_pkg::VAL_W-1:0]       m_axis_tdata,
    output logic                              m_axis_tuser,   // next_moving
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pau_pkg::ADDR_W-1:0]        paddr,
    input  logic [pau_pkg::DATA_W-1:0]        pwdata,
    output logic [pau_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    pau_pkg::cfg_t                      cfg_reg;
    logic [pau_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                               adv;
    logic [pau_pkg::VAL_W-1:0]          s_mag;

    logic                               f_vld, p_vld, v_vld;
    pau_pkg::side_t                     f_side, p_side, v_side;
    logic [pau_pkg::D2_W-1:0]           f_d2;
    logic [pau_pkg::DIST_W-1:0]         p_dist;
    logic                               p_ovf;
    logic [pau_pkg::PQ_W-1:0]           p_raw;
    logic [pau_pkg::CHG_W-1:0]          v_mx, v_my;
    logic                               v_negx, v_negy;

    logic                               out_vld_reg;
    logic [4*pau_pkg::VAL_W-1:0]        out_data_reg, out_data_next;
    logic                               out_mov_reg, out_mov_next;
    logic signed [pau_pkg::VAL_W-1:0]   nx, ny, nvx, nvy;

    // configuration registers
    assign reg_idx = paddr[pau_pkg::ADDR_W-1:pau_pkg::ADDR_LSB];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx)
                pau_pkg::REG_ENABLE:   cfg_reg.enable   <= pwdata[0];
                pau_pkg::REG_ATTR_X:   cfg_reg.ax       <= pwdata[pau_pkg::AXIS_W-1:0];
                pau_pkg::REG_ATTR_Y:   cfg_reg.ay       <= pwdata[pau_pkg::AXIS_W-1:0];
                pau_pkg::REG_STRENGTH: cfg_reg.strength <= pwdata[pau_pkg::VAL_W-1:0];
                default:               cfg_reg          <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pau_pkg::REG_ENABLE:
                prdata = {{(pau_pkg::DATA_W-1){1'b0}}, cfg_reg.enable};
            pau_pkg::REG_ATTR_X:
                prdata = {{(pau_pkg::DATA_W-pau_pkg::AXIS_W){1'b0}}, cfg_reg.ax};
            pau_pkg::REG_ATTR_Y:
                prdata = {{(pau_pkg::DATA_W-pau_pkg::AXIS_W){1'b0}}, cfg_reg.ay};
            pau_pkg::REG_STRENGTH:
                prdata = {{(pau_pkg::DATA_W-pau_pkg::VAL_W){1'b0}}, cfg_reg.strength};
            default:
                prdata = '0;
        endcase
    end

    assign s_mag = cfg_reg.strength[pau_pkg::VAL_W-1] ? -cfg_reg.strength : cfg_reg.strength;

    // whole pipeline moves when the output slot is free or being taken
    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    pau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (s_axis_tvalid),
        .pos_x    (s_axis_tdata[pau_pkg::VAL_W-1:0]),
        .pos_y    (s_axis_tdata[2*pau_pkg::VAL_W-1:pau_pkg::VAL_W]),
        .vel_x    (s_axis_tdata[3*pau_pkg::VAL_W-1:2*pau_pkg::VAL_W]),
        .vel_y    (s_axis_tdata[4*pau_pkg::VAL_W-1:3*pau_pkg::VAL_W]),
        .moving   (s_axis_tuser),
        .cfg      (cfg_reg),
        .out_vld  (f_vld),
        .out_side (f_side),
        .d2       (f_d2)
    );

    pau_pull u_pull (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_vld    (f_vld),
        .in_side   (f_side),
        .d2        (f_d2),
        .s_mag     (s_mag),
        .out_vld   (p_vld),
        .out_side  (p_side),
        .root_dist (p_dist),
        .ovf       (p_ovf),
        .raw       (p_raw)
    );

    pau_vel u_vel (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_vld    (p_vld),
        .in_side   (p_side),
        .root_dist (p_dist),
        .ovf       (p_ovf),
        .raw       (p_raw),
        .strength  (cfg_reg.strength),
        .s_mag     (s_mag),
        .out_vld   (v_vld),
        .out_side  (v_side),
        .mx        (v_mx),
        .my        (v_my),
        .negx      (v_negx),
        .negy      (v_negy)
    );

    // final velocity, bounds reset and flag
    always_comb
    begin
        nx  = v_side.oob ? '0 : v_side.px[pau_pkg::VAL_W-1:0];
        ny  = v_side.oob ? '0 : v_side.py[pau_pkg::VAL_W-1:0];
        nvx = v_side.act ? pau_pkg::sat_vel(v_side.vx, v_mx, v_negx) : v_side.vx;
        nvy = v_side.act ? pau_pkg::sat_vel(v_side.vy, v_my, v_negy) : v_side.vy;
        out_data_next = {nvy, nvx, ny, nx};
        out_mov_next  = v_side.moving && !v_side.stop;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= v_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_mov_reg  <= out_mov_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_mov_reg;

    // a still-moving particle always ends inside the bounds
    a_moving_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            ($signed(m_axis_tdata[pau_pkg::VAL_W-1:0]) <= pau_pkg::VAL_TWO &&
             $signed(m_axis_tdata[pau_pkg::VAL_W-1:0]) >= pau_pkg::VAL_NEG_TWO &&
             $signed(m_axis_tdata[2*pau_pkg::VAL_W-1:pau_pkg::VAL_W]) <= pau_pkg::VAL_TWO &&
             $signed(m_axis_tdata[2*pau_pkg::VAL_W-1:pau_pkg::VAL_W]) >= pau_pkg::VAL_NEG_TWO))
        else $error("moving particle left the bounds");

    // a waiting result blocks new input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    // enable register reads back what was written
    a_enable_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && reg_idx == pau_pkg::REG_ENABLE)
            ##1 (reg_idx == pau_pkg::REG_ENABLE) |-> (prdata[0] == $past(pwdata[0])))
        else $error("enable register readback mismatch");

endmodule

>>> design/pau_front.sv
// ============================================================================
// pau_front
// Position step, attractor clamp, offsets and squared distance (3 stages).
// ============================================================================
module pau_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_vld,
    input  logic signed [pau_pkg::VAL_W-1:0]   pos_x,
    input  logic signed [pau_pkg::VAL_W-1:0]   pos_y,
    input  logic signed [pau_pkg::VAL_W-1:0]   vel_x,
    input  logic signed [pau_pkg::VAL_W-1:0]   vel_y,
    input  logic                               moving,
    input  pau_pkg::cfg_t                      cfg,
    output logic                               out_vld,
    output pau_pkg::side_t                     out_side,
    output logic [pau_pkg::D2_W-1:0]           d2
);

    logic                               vld1_reg, vld2_reg, vld3_reg;
    pau_pkg::side_t                     side1_reg, side2_reg, side3_reg;
    pau_pkg::side_t                     side1_next, side2_next, side3_next;
    logic signed [pau_pkg::AXIS_W-1:0]  axc_reg, ayc_reg, axc_next, ayc_next;
    logic [pau_pkg::SQ_W-1:0]           sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic [pau_pkg::D2_W-1:0]           d2_reg, d2_next;
    logic signed [pau_pkg::OFF_W-1:0]   dx, dy;

    // stage 1: step the position, clamp the attractor point
    always_comb
    begin
        side1_next        = '0;
        side1_next.px     = {pos_x[pau_pkg::VAL_W-1], pos_x};
        side1_next.py     = {pos_y[pau_pkg::VAL_W-1], pos_y};
        if (moving)
        begin
            side1_next.px = $signed({pos_x[pau_pkg::VAL_W-1], pos_x})
                          + $signed({vel_x[pau_pkg::VAL_W-1], vel_x});
            side1_next.py = $signed({pos_y[pau_pkg::VAL_W-1], pos_y})
                          + $signed({vel_y[pau_pkg::VAL_W-1], vel_y});
        end
        side1_next.vx     = vel_x;
        side1_next.vy     = vel_y;
        side1_next.moving = moving;

        axc_next = cfg.ax;
        if (cfg.ax > pau_pkg::AXIS_ONE)
            axc_next = pau_pkg::AXIS_ONE;
        else if (cfg.ax < pau_pkg::AXIS_NEG_ONE)
            axc_next = pau_pkg::AXIS_NEG_ONE;
        ayc_next = cfg.ay;
        if (cfg.ay > pau_pkg::AXIS_ONE)
            ayc_next = pau_pkg::AXIS_ONE;
        else if (cfg.ay < pau_pkg::AXIS_NEG_ONE)
            ayc_next = pau_pkg::AXIS_NEG_ONE;
    end

    // stage 2: offsets and their squares, bounds check
    always_comb
    begin
        dx = $signed({side1_reg.px[pau_pkg::POS_W-1], side1_reg.px})
           - $signed({{(pau_pkg::OFF_W-pau_pkg::AXIS_W){axc_reg[pau_pkg::AXIS_W-1]}}, axc_reg});
        dy = $signed({side1_reg.py[pau_pkg::POS_W-1], side1_reg.py})
           - $signed({{(pau_pkg::OFF_W-pau_pkg::AXIS_W){ayc_reg[pau_pkg::AXIS_W-1]}}, ayc_reg});
        side2_next       = side1_reg;
        side2_next.dxneg = dx[pau_pkg::OFF_W-1];
        side2_next.dyneg = dy[pau_pkg::OFF_W-1];
        side2_next.dxmag = pau_pkg::off_mag(dx);
        side2_next.dymag = pau_pkg::off_mag(dy);
        side2_next.oob   = side1_reg.moving &&
                           (side1_reg.px > pau_pkg::POS_TWO || side1_reg.px < pau_pkg::POS_NEG_TWO ||
                            side1_reg.py > pau_pkg::POS_TWO || side1_reg.py < pau_pkg::POS_NEG_TWO);
        sqx_next = side2_next.dxmag * side2_next.dxmag;
        sqy_next = side2_next.dymag * side2_next.dymag;
    end

    // stage 3: squared distance, zero-distance stop
    always_comb
    begin
        d2_next         = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        side3_next      = side2_reg;
        side3_next.act  = side2_reg.moving && cfg.enable && (d2_next != '0);
        side3_next.stop = side2_reg.moving && cfg.enable && (d2_next == '0);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg <= side1_next;
            axc_reg   <= axc_next;
            ayc_reg   <= ayc_next;
            side2_reg <= side2_next;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            side3_reg <= side3_next;
            d2_reg    <= d2_next;
        end
    end

    assign out_vld  = vld3_reg;
    assign out_side = side3_reg;
    assign d2       = d2_reg;

endmodule

>>> design/pau_pull.sv
// ============================================================================
// pau_pull
// Pipelined square root of the squared distance beside a pipelined
// restoring divide of strength * 2^(2F) by it, one step per stage.
// ============================================================================
module pau_pull (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_vld,
    input  pau_pkg::side_t                     in_side,
    input  logic [pau_pkg::D2_W-1:0]           d2,
    input  logic [pau_pkg::VAL_W-1:0]          s_mag,
    output logic                               out_vld,
    output pau_pkg::side_t                     out_side,
    output logic [pau_pkg::DIST_W-1:0]         root_dist,
    output logic                               ovf,
    output logic [pau_pkg::PQ_W-1:0]           raw
);

    localparam int N = pau_pkg::PULL_STG;

    logic                               vld_in   [N];
    pau_pkg::side_t                     side_in  [N];
    logic [pau_pkg::PDIV_W-1:0]         rem_in   [N];
    logic [pau_pkg::D2_W-1:0]           dv_in    [N];
    logic [pau_pkg::PQ_W:0]             q_in     [N];
    logic [pau_pkg::RAD_W-1:0]          rad_in   [N];
    logic [pau_pkg::DIST_W-1:0]         root_in  [N];
    logic [pau_pkg::SREM_W-1:0]         srem_in  [N];

    logic                               vld_reg  [N];
    pau_pkg::side_t                     side_reg [N];
    logic [pau_pkg::PDIV_W-1:0]         rem_reg  [N];
    logic [pau_pkg::D2_W-1:0]           dv_reg   [N];
    logic [pau_pkg::PQ_W:0]             q_reg    [N];
    logic [pau_pkg::RAD_W-1:0]          rad_reg  [N];
    logic [pau_pkg::DIST_W-1:0]         root_reg [N];
    logic [pau_pkg::SREM_W-1:0]         srem_reg [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : gen_stg
            logic [pau_pkg::PDIV_W-1:0]  rem_next;
            logic [pau_pkg::PQ_W:0]      q_next;
            logic [pau_pkg::RAD_W-1:0]   rad_next;
            logic [pau_pkg::DIST_W-1:0]  root_next;
            logic [pau_pkg::SREM_W-1:0]  srem_next;
            logic [pau_pkg::SREM_W-1:0]  sr2;
            logic [pau_pkg::SREM_W-1:0]  trial;

            // stage input
            if (k == 0)
            begin : gen_src
                assign vld_in[k]  = in_vld;
                assign side_in[k] = in_side;
                assign rem_in[k]  = pau_pkg::PDIV_W'(s_mag) << (2 * pau_pkg::FRAC_BITS);
                assign dv_in[k]   = d2;
                assign q_in[k]    = '0;
                assign rad_in[k]  = pau_pkg::RAD_W'(d2);
                assign root_in[k] = '0;
                assign srem_in[k] = '0;
            end
            else
            begin : gen_chain
                assign vld_in[k]  = vld_reg[k-1];
                assign side_in[k] = side_reg[k-1];
                assign rem_in[k]  = rem_reg[k-1];
                assign dv_in[k]   = dv_reg[k-1];
                assign q_in[k]    = q_reg[k-1];
                assign rad_in[k]  = rad_reg[k-1];
                assign root_in[k] = root_reg[k-1];
                assign srem_in[k] = srem_reg[k-1];
            end

            // one root digit
            always_comb
            begin
                sr2      = {srem_in[k][pau_pkg::SREM_W-3:0],
                            rad_in[k][pau_pkg::RAD_W-1:pau_pkg::RAD_W-2]};
                trial    = {{(pau_pkg::SREM_W-pau_pkg::DIST_W-2){1'b0}}, root_in[k], 2'b01};
                rad_next = {rad_in[k][pau_pkg::RAD_W-3:0], 2'b00};
                if (sr2 >= trial)
                begin
                    srem_next = sr2 - trial;
                    root_next = {root_in[k][pau_pkg::DIST_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = sr2;
                    root_next = {root_in[k][pau_pkg::DIST_W-2:0], 1'b0};
                end
            end

            // one quotient bit, overflow bit first
            if (k <= pau_pkg::PQ_W)
            begin : gen_div
                logic [pau_pkg::PDIV_W-1:0] dsh;
                always_comb
                begin
                    dsh = pau_pkg::PDIV_W'(dv_in[k]) << (pau_pkg::PQ_W - k);
                    if (rem_in[k] >= dsh)
                    begin
                        rem_next = rem_in[k] - dsh;
                        q_next   = {q_in[k][pau_pkg::PQ_W-1:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_in[k];
                        q_next   = {q_in[k][pau_pkg::PQ_W-1:0], 1'b0};
                    end
                end
            end
            else
            begin : gen_hold
                assign rem_next = rem_in[k];
                assign q_next   = q_in[k];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (adv)
                    vld_reg[k] <= vld_in[k];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    side_reg[k] <= side_in[k];
                    rem_reg[k]  <= rem_next;
                    dv_reg[k]   <= dv_in[k];
                    q_reg[k]    <= q_next;
                    rad_reg[k]  <= rad_next;
                    root_reg[k] <= root_next;
                    srem_reg[k] <= srem_next;
                end
            end
        end
    endgenerate

    assign out_vld   = vld_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign root_dist = root_reg[N-1];
    assign ovf       = q_reg[N-1][pau_pkg::PQ_W];
    assign raw       = q_reg[N-1][pau_pkg::PQ_W-1:0];

endmodule

>>> design/pau_vel.sv
// ============================================================================
// pau_vel
// Pull clamp, pull times offset, then a pipelined restoring divide by the
// distance for both axes, one quotient bit per stage.
// ============================================================================
module pau_vel (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_vld,
    input  pau_pkg::side_t                     in_side,
    input  logic [pau_pkg::DIST_W-1:0]         root_dist,
    input  logic                               ovf,
    input  logic [pau_pkg::PQ_W-1:0]           raw,
    input  logic signed [pau_pkg::VAL_W-1:0]   strength,
    input  logic [pau_pkg::VAL_W-1:0]          s_mag,
    output logic                               out_vld,
    output pau_pkg::side_t                     out_side,
    output logic [pau_pkg::CHG_W-1:0]          mx,
    output logic [pau_pkg::CHG_W-1:0]          my,
    output logic                               negx,
    output logic                               negy
);

    localparam int N = pau_pkg::VEL_STG;

    // pull clamp stage
    logic                               vlda_reg;
    pau_pkg::side_t                     sidea_reg;
    logic [pau_pkg::DIST_W-1:0]         dista_reg;
    logic [pau_pkg::VAL_W-1:0]          pmag_reg, pmag_next;
    logic                               pneg_reg, pneg_next;
    logic                               big;

    // product stage
    logic                               vldb_reg;
    pau_pkg::side_t                     sideb_reg;
    logic [pau_pkg::DIST_W-1:0]         distb_reg;
    logic [pau_pkg::PROD_W-1:0]         prod_reg [2];
    logic                               sgn_reg  [2];

    // divide stages
    logic                               vld_in   [N];
    pau_pkg::side_t                     side_in  [N];
    logic [pau_pkg::DIST_W-1:0]         dv_in    [N];
    logic [pau_pkg::VDIV_W-1:0]         rem_in   [N][2];
    logic [pau_pkg::VQ_W:0]             q_in     [N][2];
    logic                               sgn_in   [N][2];
    logic                               vld_reg  [N];
    pau_pkg::side_t                     side_reg [N];
    logic [pau_pkg::DIST_W-1:0]         dv_reg   [N];
    logic [pau_pkg::VDIV_W-1:0]         rem_reg  [N][2];
    logic [pau_pkg::VQ_W:0]             q_reg    [N][2];
    logic                               sgn_reg2 [N][2];

    // pull magnitude and sign as the clamp against strength leaves them
    always_comb
    begin
        big = ovf || (raw > s_mag);
        if (!strength[pau_pkg::VAL_W-1])
        begin
            pmag_next = big ? s_mag : raw;
            pneg_next = 1'b0;
        end
        else
        begin
            pmag_next = s_mag;
            pneg_next = !big;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlda_reg <= 1'b0;
            vldb_reg <= 1'b0;
        end
        else if (adv)
        begin
            vlda_reg <= in_vld;
            vldb_reg <= vlda_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sidea_reg   <= in_side;
            dista_reg   <= root_dist;
            pmag_reg    <= pmag_next;
            pneg_reg    <= pneg_next;
            sideb_reg   <= sidea_reg;
            distb_reg   <= dista_reg;
            prod_reg[0] <= pmag_reg * sidea_reg.dxmag;
            prod_reg[1] <= pmag_reg * sidea_reg.dymag;
            sgn_reg[0]  <= pneg_reg ^ sidea_reg.dxneg;
            sgn_reg[1]  <= pneg_reg ^ sidea_reg.dyneg;
        end
    end

    genvar k, a;
    generate
        for (k = 0; k < N; k++)
        begin : gen_stg
            if (k == 0)
            begin : gen_src
                assign vld_in[k]  = vldb_reg;
                assign side_in[k] = sideb_reg;
                assign dv_in[k]   = distb_reg;
            end
            else
            begin : gen_chain
                assign vld_in[k]  = vld_reg[k-1];
                assign side_in[k] = side_reg[k-1];
                assign dv_in[k]   = dv_reg[k-1];
            end

            for (a = 0; a < 2; a++)
            begin : gen_lane
                logic [pau_pkg::VDIV_W-1:0] dsh;
                logic [pau_pkg::VDIV_W-1:0] rem_next;
                logic [pau_pkg::VQ_W:0]     q_next;

                if (k == 0)
                begin : gen_src
                    assign rem_in[k][a] = pau_pkg::VDIV_W'(prod_reg[a]);
                    assign q_in[k][a]   = '0;
                    assign sgn_in[k][a] = sgn_reg[a];
                end
                else
                begin : gen_chain
                    assign rem_in[k][a] = rem_reg[k-1][a];
                    assign q_in[k][a]   = q_reg[k-1][a];
                    assign sgn_in[k][a] = sgn_reg2[k-1][a];
                end

                // one quotient bit, clamp bit first
                always_comb
                begin
                    dsh = pau_pkg::VDIV_W'(dv_in[k]) << (pau_pkg::VQ_W - k);
                    if (rem_in[k][a] >= dsh)
                    begin
                        rem_next = rem_in[k][a] - dsh;
                        q_next   = {q_in[k][a][pau_pkg::VQ_W-1:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_in[k][a];
                        q_next   = {q_in[k][a][pau_pkg::VQ_W-1:0], 1'b0};
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rem_reg[k][a]  <= rem_next;
                        q_reg[k][a]    <= q_next;
                        sgn_reg2[k][a] <= sgn_in[k][a];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (adv)
                    vld_reg[k] <= vld_in[k];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    side_reg[k] <= side_in[k];
                    dv_reg[k]   <= dv_in[k];
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[N-1];
    assign out_side = side_reg[N-1];
    assign mx       = q_reg[N-1][0][pau_pkg::VQ_W] ? pau_pkg::CHG_LIM
                                                   : {1'b0, q_reg[N-1][0][pau_pkg::VQ_W-1:0]};
    assign my       = q_reg[N-1][1][pau_pkg::VQ_W] ? pau_pkg::CHG_LIM
                                                   : {1'b0, q_reg[N-1][1][pau_pkg::VQ_W-1:0]};
    assign negx     = sgn_reg2[N-1][0];
    assign negy     = sgn_reg2[N-1][1];

endmodule
